@@ src/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");

// clocked assertion that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");

`endif

@@ src/lz77td_pkg.sv @@
// package: item types and default sizes of the lz77 token decoder
`default_nettype none
package lz77td_pkg;

  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int MAX_COPY_DEF    = 63;

  localparam int DIST_W = 12;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  typedef struct packed {
    logic [DIST_W-1:0] back_distance;
    logic [LEN_W-1:0]  copy_length;
    logic [BYTE_W-1:0] next_byte;
  } tok_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              bad_reference;
  } res_t;

endpackage
`default_nettype wire

@@ src/lz77td_history.sv @@
// history window memory: one write port, one registered read port
`default_nettype none
module lz77td_history #(
  parameter int DEPTH = lz77td_pkg::WINDOW_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [lz77td_pkg::BYTE_W-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [lz77td_pkg::BYTE_W-1:0] rdata
);
  import lz77td_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/lz77td_ctrl.sv @@
// token sequencer: pointers, copy issue, read stage and write-back with forwarding
`default_nettype none
module lz77td_ctrl #(
  parameter int WINDOW_SIZE = lz77td_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_COPY    = lz77td_pkg::MAX_COPY_DEF,
  parameter int AW          = $clog2(WINDOW_SIZE)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tok_valid,
  output logic                               tok_ready,
  input  wire lz77td_pkg::tok_t              tok,
  input  wire logic                          adv,
  output logic                               push,
  output lz77td_pkg::res_t                   res,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [lz77td_pkg::BYTE_W-1:0] mem_wdata,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [lz77td_pkg::BYTE_W-1:0] mem_rdata
);
  import lz77td_pkg::*;

  localparam int HW = $clog2(WINDOW_SIZE + 1);
  localparam int CW = ((HW > DIST_W) ? HW : DIST_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_COPY, S_TAIL} state_t;

  state_t            state;
  logic [AW-1:0]     wp;
  logic [HW-1:0]     held;
  logic [AW-1:0]     rd;
  logic [LEN_W-1:0]  cnt;
  logic [BYTE_W-1:0] nb;
  logic              bad;

  logic              d_valid;
  logic              d_mem;
  logic              d_last;
  logic              d_bad;
  logic              d_fwd;
  logic [BYTE_W-1:0] d_nb;
  logic [BYTE_W-1:0] fwd_byte;

  logic              issue;
  logic              commit;
  logic              accept;
  logic [BYTE_W-1:0] d_byte;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     rd_inc;
  logic [CW-1:0]     dist_ext;
  logic [CW-1:0]     held_ext;
  logic [CW-1:0]     wp_ext;
  logic [CW-1:0]     rd_full;
  logic [AW-1:0]     rd_start;
  logic [LEN_W-1:0]  len_sat;
  logic              no_copy;

  assign issue  = adv && (state == S_COPY || state == S_TAIL);
  assign commit = adv && d_valid;
  assign d_byte = d_fwd ? fwd_byte : (d_mem ? mem_rdata : d_nb);

  assign push      = commit;
  assign res       = '{out_byte: d_byte, last: d_last, bad_reference: d_bad};
  assign mem_we    = commit;
  assign mem_waddr = wp;
  assign mem_wdata = d_byte;
  assign mem_re    = adv && (state == S_COPY);
  assign mem_raddr = rd;

  // a token is taken only once the previous one has fully written back
  assign tok_ready = (state == S_IDLE) && !d_valid;
  assign accept    = tok_valid && tok_ready;

  assign wp_inc = (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + 1'b1;
  assign rd_inc = (rd == AW'(WINDOW_SIZE - 1)) ? '0 : rd + 1'b1;

  assign dist_ext = CW'(tok.back_distance);
  assign held_ext = CW'(held);
  assign wp_ext   = CW'(wp);
  assign rd_full  = (wp_ext >= dist_ext) ? wp_ext - dist_ext
                                         : wp_ext + CW'(WINDOW_SIZE) - dist_ext;
  assign rd_start = rd_full[AW-1:0];
  assign len_sat  = (tok.copy_length > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                         : tok.copy_length;
  assign no_copy  = (tok.back_distance == '0) || (dist_ext > held_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      held    <= '0;
      d_valid <= 1'b0;
    end else begin
      if (commit) begin
        wp <= wp_inc;
        if (held != HW'(WINDOW_SIZE)) begin
          held <= held + 1'b1;
        end
      end
      if (adv) begin
        d_valid <= issue;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (no_copy || len_sat == '0) begin
              state <= S_TAIL;
            end else begin
              state <= S_COPY;
            end
          end
        end
        S_COPY: begin
          if (adv && cnt == LEN_W'(1)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nb  <= tok.next_byte;
      bad <= no_copy && (tok.back_distance != '0);
      rd  <= rd_start;
      cnt <= len_sat;
    end
    if (adv && state == S_COPY) begin
      rd       <= rd_inc;
      cnt      <= cnt - 1'b1;
      d_mem    <= 1'b1;
      d_last   <= 1'b0;
      d_bad    <= 1'b0;
      // distance one reads the byte being written this very cycle
      d_fwd    <= commit && (rd == wp);
      fwd_byte <= d_byte;
    end
    if (adv && state == S_TAIL) begin
      d_mem  <= 1'b0;
      d_last <= 1'b1;
      d_bad  <= bad;
      d_nb   <= nb;
      d_fwd  <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/lz77_token_decoder_unit.sv @@
// Decodes LZ77 tokens into bytes, one byte per cycle through a history window
// held in a single synchronous memory. A literal token or one whose distance
// exceeds the bytes held gives one byte; a copy of length L (saturated to
// MAX_COPY) gives L+1 bytes. The block takes the token, makes one memory
// read per copied byte, then issues the trailing byte, and writes the last byte
// back before the next token is taken. A byte waiting at the output stalls
// the whole datapath until it is taken. Window entries are never cleared: the
// distance check keeps reads on written entries, so the block is ready right
// after reset.
`default_nettype none
module lz77_token_decoder_unit #(
  parameter int WINDOW_SIZE = lz77td_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_COPY    = lz77td_pkg::MAX_COPY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lz77td_pkg::tok_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lz77td_pkg::res_t      out_item
);
  import lz77td_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);

  logic              adv;
  logic              push;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // the whole datapath moves only when the output slot is free or draining
  assign adv = !out_valid || out_ready;

  lz77td_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_COPY    (MAX_COPY),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (in_valid),
    .tok_ready (in_ready),
    .tok       (in_item),
    .adv       (adv),
    .push      (push),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lz77td_history #(
    .DEPTH (WINDOW_SIZE),
    .AW    (AW)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

@@ src/lz77td_checker.sv @@
// port-level checker for the token decoder and its bind
`default_nettype none
`include "assert_macros.svh"
module lz77td_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire lz77td_pkg::res_t out_item
);
  import lz77td_pkg::*;

  logic in_take;
  assign in_take = in_valid && in_ready;

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item))
  // a byte that is not the last of its token means the token is still in flight
  `ASSERT_CLK(a_busy_mid_token, clk, rst, out_valid && !out_item.last |-> !in_ready)
  `ASSERT_CLK(a_bad_is_last, clk, rst, out_valid && out_item.bad_reference |-> out_item.last)
  `ASSERT_CLK(a_one_token, clk, rst, in_take |=> !in_ready)

endmodule

bind lz77_token_decoder_unit lz77td_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
